// File: src/dtoi_pkg.sv
// Shared types and constants for the decimal string to 64-bit integer converter.
// Used by every module of the block; it depends on nothing else.
package dtoi_pkg;

	localparam int unsigned CharWidth = 8;
	localparam int unsigned ValueWidth = 64;

	localparam logic [CharWidth-1:0] CharNul = 8'd0;
	localparam logic [CharWidth-1:0] CharTab = 8'd9;
	localparam logic [CharWidth-1:0] CharCr = 8'd13;
	localparam logic [CharWidth-1:0] CharSpace = 8'd32;
	localparam logic [CharWidth-1:0] CharPlus = 8'd43;
	localparam logic [CharWidth-1:0] CharMinus = 8'd45;
	localparam logic [CharWidth-1:0] CharZero = 8'd48;
	localparam logic [CharWidth-1:0] CharNine = 8'd57;

	localparam logic [ValueWidth-1:0] LimitPos = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [ValueWidth-1:0] LimitNeg = 64'h8000_0000_0000_0000;
	localparam logic [ValueWidth-1:0] ScaleLimit = 64'd922337203685477580;
	localparam logic [3:0] LastDigitMax = 4'd8;

	typedef enum logic [1:0] {
		PH_LEAD  = 2'd0,
		PH_BODY  = 2'd1,
		PH_TRAIL = 2'd2,
		PH_BAD   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [CharWidth-1:0] character;
		logic                 last;
	} char_t;

	typedef struct packed {
		logic                         fits;
		logic signed [ValueWidth-1:0] value;
	} result_t;

endpackage

// File: src/dtoi_in_stage.sv
// Input register stage of the converter: holds one character request.
// Depends on dtoi_pkg for the character request type.
module dtoi_in_stage
	import dtoi_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  char_valid,
	output logic  char_stall,
	input  char_t char_data,
	input  logic  take,
	output logic  valid_s1,
	output char_t data_s1
);

	logic load;

	assign load = !valid_s1 || take;
	assign char_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && char_valid) begin
			data_s1 <= char_data;
		end
	end

endmodule

// File: src/dtoi_parse.sv
// Parse state and range check: folds one character into the running state and
// forms the result on the last character. Depends on dtoi_pkg.
module dtoi_parse
	import dtoi_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  char_t   data_s1,
	output result_t result
);

	phase_t                phase_q, phase_d;
	logic                  negative_q, negative_d;
	logic [ValueWidth-1:0] magnitude_q, magnitude_d;
	logic                  too_large_q, too_large_d;
	logic                  ended_q, ended_d;

	logic [CharWidth-1:0]  c;
	logic                  is_ws, is_dig, is_sgn;
	logic [3:0]            digit;
	logic                  ok;
	logic                  take_digit;

	assign c = data_s1.character;
	assign is_ws = (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
	assign is_dig = (c >= CharZero) && (c <= CharNine);
	assign is_sgn = (c == CharPlus) || (c == CharMinus);
	assign digit = 4'(c - CharZero);

	always_comb begin
		phase_d = phase_q;
		negative_d = negative_q;
		magnitude_d = magnitude_q;
		too_large_d = too_large_q;
		ended_d = ended_q;
		take_digit = 1'b0;
		if (!ended_q) begin
			if (c == CharNul) begin
				ended_d = 1'b1;
			end else begin
				case (phase_q)
					PH_LEAD: begin
						if (is_ws) begin
							phase_d = PH_LEAD;
						end else if (is_sgn) begin
							negative_d = (c == CharMinus);
							phase_d = PH_BODY;
						end else if (is_dig) begin
							take_digit = 1'b1;
							phase_d = PH_BODY;
						end else begin
							phase_d = PH_BAD;
						end
					end
					PH_BODY: begin
						if (is_dig) begin
							take_digit = 1'b1;
						end else if (is_ws) begin
							phase_d = PH_TRAIL;
						end else begin
							phase_d = PH_BAD;
						end
					end
					PH_TRAIL: begin
						if (!is_ws) begin
							phase_d = PH_BAD;
						end
					end
					default: begin
						phase_d = PH_BAD;
					end
				endcase
			end
		end
		if (take_digit && !too_large_q) begin
			if ((magnitude_q > ScaleLimit) ||
				((magnitude_q == ScaleLimit) && (digit > LastDigitMax))) begin
				too_large_d = 1'b1;
			end else begin
				magnitude_d = (magnitude_q << 3) + (magnitude_q << 1) +
					{{(ValueWidth-4){1'b0}}, digit};
			end
		end
	end

	always_comb begin
		ok = (phase_d != PH_BAD) && !too_large_d &&
			(negative_d ? (magnitude_d <= LimitNeg) : (magnitude_d <= LimitPos));
		result.fits = ok;
		if (!ok) begin
			result.value = '0;
		end else if (negative_d) begin
			result.value = -$signed(magnitude_d);
		end else begin
			result.value = $signed(magnitude_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			negative_q <= 1'b0;
			magnitude_q <= '0;
			too_large_q <= 1'b0;
			ended_q <= 1'b0;
		end else if (step) begin
			if (data_s1.last) begin
				phase_q <= PH_LEAD;
				negative_q <= 1'b0;
				magnitude_q <= '0;
				too_large_q <= 1'b0;
				ended_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				negative_q <= negative_d;
				magnitude_q <= magnitude_d;
				too_large_q <= too_large_d;
				ended_q <= ended_d;
			end
		end
	end

endmodule

// File: src/dtoi_out_reg.sv
// Result register of the converter: holds one result request until taken.
// Depends on dtoi_pkg for the result request type.
module dtoi_out_reg
	import dtoi_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	output logic    free,
	output logic    res_valid,
	input  logic    res_stall,
	output result_t res_data
);

	assign free = !res_valid || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (free) begin
			res_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_data <= result;
		end
	end

endmodule

// File: src/decimal_to_int64_checked.sv
// Decimal string to signed 64-bit integer converter with range check.
// Top level; instantiates dtoi_in_stage, dtoi_parse and dtoi_out_reg.
//
// Usage: the sender streams a string one character request per cycle on the
// char channel (char_valid, char_stall, char_data) and marks the final
// character with last. Each string gives exactly one result request on the
// res channel (res_valid, res_stall, res_data), carrying fits and the signed
// value, which is zero when fits is low.
// Throughput is one character per cycle unless a last character waits for the
// result register. Each character updates the parse state (a times-ten shift-add
// and a constant compare) on leaving the input register; a last one also loads
// the result register. While the receiver stalls, the result is held; characters
// that are not last keep flowing, and a last character waits in the input register
// until the result register is free, which stalls the sender.
// Reset clears the parse state and both valid flags; no request is lost
// across strings since the state returns to its start with each result.
module decimal_to_int64_checked
	import dtoi_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    char_valid,
	output logic    char_stall,
	input  char_t   char_data,
	output logic    res_valid,
	input  logic    res_stall,
	output result_t res_data
);

	logic    valid_s1;
	char_t   data_s1;
	logic    take;
	logic    out_free;
	result_t result;

	assign take = valid_s1 && (!data_s1.last || out_free);

	dtoi_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.take       (take),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	dtoi_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (take),
		.data_s1 (data_s1),
		.result  (result)
	);

	dtoi_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && data_s1.last),
		.result    (result),
		.free      (out_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for decimal_to_int64_checked: streams character requests and
// predicts each string's fits flag and value. Depends on dtoi_pkg and the top level.
// Random strings mix small numbers, values near and beyond the 64-bit limits, and noise.
module tb;
	import dtoi_pkg::*;

	class parse_scoreboard;
		phase_t              phase;
		bit                  negative;
		bit [ValueWidth-1:0] magnitude;
		bit                  too_large;
		bit                  ended;
		result_t             expected_results[$];
		int                  failures;

		function new();
			failures = 0;
			restart();
		endfunction

		function void restart();
			phase = PH_LEAD;
			negative = 1'b0;
			magnitude = '0;
			too_large = 1'b0;
			ended = 1'b0;
		endfunction

		function bit is_space(bit [CharWidth-1:0] c);
			return c == CharSpace || (c >= CharTab && c <= CharCr);
		endfunction

		function void add_digit(bit [3:0] d);
			if (too_large) begin
				return;
			end
			if (magnitude > ScaleLimit || (magnitude == ScaleLimit && d > LastDigitMax)) begin
				too_large = 1'b1;
			end else begin
				magnitude = magnitude * 10 + ValueWidth'(d);
			end
		endfunction

		function void take_char(bit [CharWidth-1:0] c);
			bit ws;
			bit dig;
			bit sgn;
			bit [CharWidth-1:0] offset;
			ws = is_space(c);
			dig = c >= CharZero && c <= CharNine;
			sgn = c == CharPlus || c == CharMinus;
			offset = c - CharZero;
			case (phase)
				PH_LEAD: begin
					if (ws) begin
						phase = PH_LEAD;
					end else if (sgn) begin
						negative = c == CharMinus;
						phase = PH_BODY;
					end else if (dig) begin
						add_digit(offset[3:0]);
						phase = PH_BODY;
					end else begin
						phase = PH_BAD;
					end
				end
				PH_BODY: begin
					if (dig) begin
						add_digit(offset[3:0]);
					end else if (ws) begin
						phase = PH_TRAIL;
					end else begin
						phase = PH_BAD;
					end
				end
				PH_TRAIL: begin
					if (!ws) begin
						phase = PH_BAD;
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void note_char(char_t req);
			result_t r;
			bit ok;
			if (!ended) begin
				if (req.character == CharNul) begin
					ended = 1'b1;
				end else begin
					take_char(req.character);
				end
			end
			if (req.last) begin
				ok = phase != PH_BAD && !too_large &&
					(negative ? magnitude <= LimitNeg : magnitude <= LimitPos);
				r.fits = ok;
				r.value = !ok ? '0 : (negative ? -magnitude : magnitude);
				expected_results.push_back(r);
				restart();
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, fits %0b value %0d", $time, got.fits,
					got.value);
				failures++;
				return;
			end
			want = expected_results.pop_front();
			if (got.fits !== want.fits) begin
				$display("%0t: fits expected %0b actual %0b", $time, want.fits, got.fits);
				failures++;
			end
			if (got.value !== want.value) begin
				$display("%0t: value expected %0d actual %0d", $time, want.value, got.value);
				failures++;
			end
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    char_valid = 1'b0;
	logic    char_stall;
	char_t   char_data = '0;
	logic    res_valid;
	logic    res_stall = 1'b0;
	result_t res_data;

	parse_scoreboard board = new();
	int          burst_left = 0;
	int          items_sent = 0;
	int unsigned cyc = 0;
	int          stall_left = 0;
	bit          stall_on = 1'b0;

	decimal_to_int64_checked u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_data (char_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				board.check_result(res_data);
			end
			if (char_valid && !char_stall) begin
				board.note_char(char_data);
			end
		end
	end

	// The receiver stalls in runs of random length, with a periodic stall-free window.
	always @(negedge clk) begin
		cyc++;
		if (stall_left == 0) begin
			stall_left = $urandom_range(1, 12);
			stall_on = $urandom_range(0, 2) == 0;
		end else begin
			stall_left--;
		end
		res_stall <= stall_on && (cyc % 1000 >= 150);
	end

	task automatic drive_char(input char_t req);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				@(negedge clk);
				char_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		char_valid <= 1'b1;
		char_data <= req;
		do @(posedge clk); while (char_stall);
	endtask

	task automatic drain_results();
		@(negedge clk);
		char_valid <= 1'b0;
		while (board.outstanding() != 0) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic send_text(input bit [CharWidth-1:0] t[$]);
		char_t req;
		foreach (t[i]) begin
			req.character = t[i];
			req.last = i == t.size() - 1;
			drive_char(req);
			items_sent++;
		end
	endtask

	function automatic bit [CharWidth-1:0] random_space();
		return ($urandom_range(0, 1) == 0) ? CharSpace : CharTab + CharWidth'($urandom_range(0, 4));
	endfunction

	task automatic make_text(output bit [CharWidth-1:0] t[$]);
		bit [CharWidth-1:0] digits[$];
		bit [ValueWidth-1:0] v;
		string s;
		int n;
		t = {};
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 6);
			repeat (n) t.push_back(CharWidth'($urandom_range(0, 255)));
			return;
		end
		s = "";
		case ($urandom_range(0, 11))
			0, 1, 2: s = $sformatf("%0d", $urandom_range(0, 99999));
			3: begin
				v = {$urandom, $urandom} >> $urandom_range(0, 63);
				s = $sformatf("%0d", v);
			end
			4, 5, 6: begin
				v = LimitPos - 64'd10 + 64'($urandom_range(0, 20));
				s = $sformatf("%0d", v);
			end
			7: begin
				n = $urandom_range(20, 26);
				digits.push_back(CharZero + CharWidth'($urandom_range(1, 9)));
				repeat (n - 1) digits.push_back(CharZero + CharWidth'($urandom_range(0, 9)));
			end
			8: begin
				repeat ($urandom_range(1, 5)) digits.push_back(CharZero);
				v = LimitPos - 64'd3 + 64'($urandom_range(0, 6));
				s = $sformatf("%0d", v);
			end
			9: digits.push_back(CharZero);
			default: begin
			end
		endcase
		for (int i = 0; i < s.len(); i++) begin
			digits.push_back(s[i]);
		end
		repeat ($urandom_range(0, 2)) t.push_back(random_space());
		case ($urandom_range(0, 3))
			0: t.push_back(CharMinus);
			1: t.push_back(CharPlus);
			default: begin
			end
		endcase
		foreach (digits[i]) t.push_back(digits[i]);
		repeat ($urandom_range(0, 2)) t.push_back(random_space());
		if ($urandom_range(0, 3) == 0 && t.size() > 0) begin
			case ($urandom_range(0, 2))
				0: t.insert($urandom_range(0, t.size()), CharWidth'($urandom_range(1, 255)));
				1: t[$urandom_range(0, t.size() - 1)] = CharWidth'($urandom_range(1, 255));
				default: begin
					t.insert($urandom_range(0, t.size()), CharNul);
					repeat ($urandom_range(0, 3)) t.push_back(CharWidth'($urandom_range(0, 255)));
				end
			endcase
		end
		if (t.size() == 0) begin
			t.push_back(CharNul);
		end
	endtask

	initial begin
		#3_000_000;
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		bit [CharWidth-1:0] t[$];
		bit drained_once;
		drained_once = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		t = '{CharNul};
		send_text(t);
		t = '{CharMinus};
		send_text(t);
		t = '{CharPlus};
		send_text(t);
		t = '{CharSpace, CharZero, CharZero, CharZero + 8'd7, CharCr};
		send_text(t);
		t = '{CharZero + 8'd4, 8'hFF};
		send_text(t);
		t = '{CharZero + 8'd9, CharNul, 8'hFF};
		send_text(t);
		t = '{CharMinus, CharTab + 8'd1};
		send_text(t);
		t = '{CharZero + 8'd1, CharSpace, CharZero + 8'd2};
		send_text(t);
		t = '{CharPlus, CharMinus};
		send_text(t);
		drain_results();

		while (items_sent < 630) begin
			make_text(t);
			send_text(t);
			if (!drained_once && items_sent > 350) begin
				drain_results();
				drained_once = 1'b1;
			end
		end

		drain_results();
		repeat (10) @(negedge clk);
		if (board.failures == 0 && board.outstanding() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end
endmodule

// File: filelist.f
src/dtoi_pkg.sv
src/dtoi_in_stage.sv
src/dtoi_parse.sv
src/dtoi_out_reg.sv
src/decimal_to_int64_checked.sv
tb/sv/tb.sv
